>>> src/lfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_pkg: shared types and constants for the line fold stream
// Character codes, command record between front and back, result record.
// ---------------------------------------------------------------------------
package lfs_pkg;

	localparam int CNT_W          = 6;
	localparam int MAX_COLUMN_DEF = 32;
	localparam int CMD_DEPTH      = 2;
	localparam int OUT_DEPTH      = 4;
	localparam int OUT_CW         = $clog2(OUT_DEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [7:0]       byte_t;

	localparam byte_t CH_SPACE   = 8'd32;
	localparam byte_t CH_HYPHEN  = 8'd45;
	localparam byte_t CH_NEWLINE = 8'd10;
	localparam cnt_t  FOLD_RESET = 6'd32;

	// literal bytes emitted after the write step
	typedef enum logic [1:0] {
		LIT_NONE,
		LIT_NL,
		LIT_CH,
		LIT_HYPH
	} lit_kind_t;

	// flush held[0 .. a_cnt-1], write, literals, flush held[1 .. b_cnt-1]
	typedef struct packed {
		cnt_t      a_cnt;
		logic      wr_en;
		cnt_t      wr_addr;
		byte_t     ch;
		lit_kind_t lit;
		cnt_t      b_cnt;
	} cmd_t;

	typedef struct packed {
		logic  last;
		byte_t ch;
	} res_t;

endpackage

`default_nettype wire

>>> src/line_fold_stream_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// line_fold_stream_top: text line folder
// Folds a byte stream at a programmable column, breaking at the last space.
//
//   channel   handshake        payload
//   input     push / full      ch
//   result    pop / empty      out_ch, last
//   config    cfg_we           cfg_wdata (fold column)
//
// The back end loads each command in its idle state, then writes the line
// buffer if the command asks and emits each literal byte (three on a hyphen
// break). Held bytes are flushed through the single buffer read port.
// The back end stalls while the four-entry result queue has no room.
// The front takes a byte per cycle while the two-entry command queue has room.
// Reset clears all control state; the line buffer needs no clearing.
// ---------------------------------------------------------------------------
module line_fold_stream_top #(
	parameter int MAX_COLUMN = lfs_pkg::MAX_COLUMN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	input  wire logic       push,
	input  wire logic [7:0] ch,
	output logic            full,
	input  wire logic       pop,
	output logic [7:0]      out_ch,
	output logic            last,
	output logic            empty
);

	lfs_pkg::cmd_t                 cmd_in;
	lfs_pkg::cmd_t                 cmd_out;
	logic                          cmd_push;
	logic                          cmd_pop;
	logic                          cmd_empty;
	logic                          of_push;
	lfs_pkg::res_t                 of_wdata;
	lfs_pkg::res_t                 of_rdata;
	logic [lfs_pkg::OUT_CW-1:0]    of_count;
	logic                          of_full;

	lfs_front #(
		.MAX_COLUMN(MAX_COLUMN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.ch       (ch),
		.cmd_full (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	lfs_fifo #(
		.WIDTH($bits(lfs_pkg::cmd_t)),
		.DEPTH(lfs_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty),
		.count ()
	);

	lfs_back #(
		.MAX_COLUMN(MAX_COLUMN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.of_count (of_count),
		.of_push  (of_push),
		.of_data  (of_wdata)
	);

	lfs_fifo #(
		.WIDTH($bits(lfs_pkg::res_t)),
		.DEPTH(lfs_pkg::OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (of_push && !of_full),
		.wdata (of_wdata),
		.full  (of_full),
		.pop   (pop),
		.rdata (of_rdata),
		.empty (empty),
		.count (of_count)
	);

	assign out_ch = of_rdata.ch;
	assign last   = of_rdata.last;

endmodule

`default_nettype wire

>>> src/lfs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_fifo: small register queue
// First-word-fall-through queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module lfs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    rd_ptr_q;
	logic [PW-1:0]    wr_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> src/lfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_front: request intake and classification
// Tracks column, held count and space mark; turns accepted bytes into commands.
// ---------------------------------------------------------------------------
module lfs_front #(
	parameter int MAX_COLUMN = lfs_pkg::MAX_COLUMN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire lfs_pkg::cnt_t cfg_wdata,
	input  wire logic          push,
	input  wire lfs_pkg::byte_t ch,
	input  wire logic          cmd_full,
	output logic               cmd_push,
	output lfs_pkg::cmd_t      cmd
);

	lfs_pkg::cnt_t fold_col_q;
	lfs_pkg::cnt_t column_q;
	lfs_pkg::cnt_t held_cnt_q;
	logic          have_space_q;
	logic          started_q;

	lfs_pkg::cnt_t max_col;
	lfs_pkg::cnt_t fold_eff;
	lfs_pkg::cnt_t col_inc;
	lfs_pkg::cnt_t new_cnt;
	logic          accept;
	logic          is_nl;
	logic          is_sp;
	logic          cnt_room;
	logic          hs_after;
	logic          fold_hit;

	assign max_col  = lfs_pkg::cnt_t'(MAX_COLUMN);
	assign accept   = push && !cmd_full;
	assign is_nl    = ch == lfs_pkg::CH_NEWLINE;
	assign is_sp    = ch == lfs_pkg::CH_SPACE;
	assign col_inc  = column_q + lfs_pkg::cnt_t'(1);
	assign cnt_room = held_cnt_q < max_col;
	assign hs_after = is_sp || have_space_q;
	assign fold_hit = !is_nl && (col_inc >= fold_eff);

	always_comb begin
		if (fold_col_q < lfs_pkg::cnt_t'(2)) begin
			fold_eff = lfs_pkg::cnt_t'(2);
		end else if (fold_col_q > max_col) begin
			fold_eff = max_col;
		end else begin
			fold_eff = fold_col_q;
		end
	end

	always_comb begin
		if (is_sp) begin
			new_cnt = lfs_pkg::cnt_t'(1);
		end else if (have_space_q && cnt_room) begin
			new_cnt = held_cnt_q + lfs_pkg::cnt_t'(1);
		end else begin
			new_cnt = held_cnt_q;
		end
	end

	always_comb begin
		cmd.ch      = ch;
		cmd.wr_en   = 1'b0;
		cmd.wr_addr = is_sp ? '0 : held_cnt_q;
		cmd.a_cnt   = '0;
		cmd.b_cnt   = '0;
		cmd.lit     = lfs_pkg::LIT_NONE;
		if (is_nl) begin
			cmd.a_cnt = held_cnt_q;
			cmd.lit   = lfs_pkg::LIT_NL;
		end else begin
			cmd.wr_en = is_sp || (have_space_q && cnt_room);
			cmd.a_cnt = is_sp ? held_cnt_q : '0;
			if (fold_hit) begin
				cmd.lit   = hs_after ? lfs_pkg::LIT_NL : lfs_pkg::LIT_HYPH;
				cmd.b_cnt = hs_after ? new_cnt : '0;
			end else if (!hs_after) begin
				cmd.lit = lfs_pkg::LIT_CH;
			end
		end
	end

	// a newline on an empty line produces no work
	assign cmd_push = accept && (!is_nl || started_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_col_q   <= lfs_pkg::FOLD_RESET;
			column_q     <= '0;
			held_cnt_q   <= '0;
			have_space_q <= 1'b0;
			started_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				fold_col_q <= cfg_wdata;
			end
			if (accept) begin
				if (is_nl) begin
					column_q     <= '0;
					held_cnt_q   <= '0;
					have_space_q <= 1'b0;
					started_q    <= 1'b0;
				end else begin
					started_q <= 1'b1;
					if (fold_hit && hs_after) begin
						column_q     <= new_cnt - lfs_pkg::cnt_t'(1);
						held_cnt_q   <= '0;
						have_space_q <= 1'b0;
					end else if (fold_hit) begin
						column_q     <= lfs_pkg::cnt_t'(1);
						held_cnt_q   <= new_cnt;
						have_space_q <= 1'b0;
					end else begin
						column_q     <= col_inc;
						held_cnt_q   <= new_cnt;
						have_space_q <= hs_after;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/lfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_back: command execution
// Sequences flushes of the held line buffer, buffer writes and literal bytes.
// ---------------------------------------------------------------------------
module lfs_back #(
	parameter int MAX_COLUMN = lfs_pkg::MAX_COLUMN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_empty,
	input  wire lfs_pkg::cmd_t               cmd,
	output logic                             cmd_pop,
	input  wire logic [lfs_pkg::OUT_CW-1:0]  of_count,
	output logic                             of_push,
	output lfs_pkg::res_t                    of_data
);

	localparam int AW = (MAX_COLUMN > 1) ? $clog2(MAX_COLUMN) : 1;
	localparam int RW = lfs_pkg::OUT_CW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH_A,
		ST_WRITE,
		ST_LIT,
		ST_FLUSH_B
	} state_t;

	function automatic state_t next_phase(lfs_pkg::cmd_t c, state_t cur);
		state_t r;
		r = ST_IDLE;
		if (cur != ST_FLUSH_B && c.b_cnt > lfs_pkg::cnt_t'(1)) begin
			r = ST_FLUSH_B;
		end
		if ((cur == ST_IDLE || cur == ST_FLUSH_A || cur == ST_WRITE) &&
		    c.lit != lfs_pkg::LIT_NONE) begin
			r = ST_LIT;
		end
		if ((cur == ST_IDLE || cur == ST_FLUSH_A) && c.wr_en) begin
			r = ST_WRITE;
		end
		if (cur == ST_IDLE && c.a_cnt != '0) begin
			r = ST_FLUSH_A;
		end
		return r;
	endfunction

	state_t          st_q;
	lfs_pkg::cmd_t   cmd_q;
	lfs_pkg::cnt_t   idx_q;
	logic [1:0]      lit_idx_q;
	logic            tok_valid_s1;
	logic            tok_mem_s1;
	lfs_pkg::byte_t  tok_byte_s1;
	logic            tok_last_s1;
	lfs_pkg::byte_t  rd_data_s1;
	lfs_pkg::byte_t  held_mem [MAX_COLUMN];

	logic            room;
	logic            has_l;
	logic            has_b;
	logic            lit_final;
	logic            mem_we;
	logic            rd_en;
	lfs_pkg::cnt_t   a_end;
	lfs_pkg::cnt_t   b_end;
	lfs_pkg::byte_t  lit_byte;

	assign room    = (RW'(of_count) + RW'(tok_valid_s1)) < RW'(lfs_pkg::OUT_DEPTH);
	assign has_l   = cmd_q.lit != lfs_pkg::LIT_NONE;
	assign has_b   = cmd_q.b_cnt > lfs_pkg::cnt_t'(1);
	assign a_end   = cmd_q.a_cnt - lfs_pkg::cnt_t'(1);
	assign b_end   = cmd_q.b_cnt - lfs_pkg::cnt_t'(1);
	assign cmd_pop = (st_q == ST_IDLE) && !cmd_empty;
	assign mem_we  = st_q == ST_WRITE;
	assign rd_en   = (st_q == ST_FLUSH_A || st_q == ST_FLUSH_B) && room;

	assign lit_final = (cmd_q.lit == lfs_pkg::LIT_HYPH) ? (lit_idx_q == 2'd2) : 1'b1;

	always_comb begin
		case (cmd_q.lit)
			lfs_pkg::LIT_NL: lit_byte = lfs_pkg::CH_NEWLINE;
			lfs_pkg::LIT_HYPH: begin
				case (lit_idx_q)
					2'd0:    lit_byte = lfs_pkg::CH_HYPHEN;
					2'd1:    lit_byte = lfs_pkg::CH_NEWLINE;
					default: lit_byte = cmd_q.ch;
				endcase
			end
			default: lit_byte = cmd_q.ch;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cmd_q        <= '0;
			idx_q        <= '0;
			lit_idx_q    <= '0;
			tok_valid_s1 <= 1'b0;
			tok_mem_s1   <= 1'b0;
			tok_byte_s1  <= '0;
			tok_last_s1  <= 1'b0;
		end else begin
			tok_valid_s1 <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q     <= cmd;
						st_q      <= next_phase(cmd, ST_IDLE);
						idx_q     <= '0;
						lit_idx_q <= '0;
					end
				end
				ST_FLUSH_A: begin
					if (room) begin
						tok_valid_s1 <= 1'b1;
						tok_mem_s1   <= 1'b1;
						tok_last_s1  <= (idx_q == a_end) && !has_l && !has_b;
						if (idx_q == a_end) begin
							st_q  <= next_phase(cmd_q, ST_FLUSH_A);
							idx_q <= lfs_pkg::cnt_t'(1);
						end else begin
							idx_q <= idx_q + lfs_pkg::cnt_t'(1);
						end
					end
				end
				ST_WRITE: begin
					st_q  <= next_phase(cmd_q, ST_WRITE);
					idx_q <= lfs_pkg::cnt_t'(1);
				end
				ST_LIT: begin
					if (room) begin
						tok_valid_s1 <= 1'b1;
						tok_mem_s1   <= 1'b0;
						tok_byte_s1  <= lit_byte;
						tok_last_s1  <= lit_final && !has_b;
						if (lit_final) begin
							st_q  <= next_phase(cmd_q, ST_LIT);
							idx_q <= lfs_pkg::cnt_t'(1);
						end else begin
							lit_idx_q <= lit_idx_q + 2'd1;
						end
					end
				end
				ST_FLUSH_B: begin
					if (room) begin
						tok_valid_s1 <= 1'b1;
						tok_mem_s1   <= 1'b1;
						tok_last_s1  <= idx_q == b_end;
						if (idx_q == b_end) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + lfs_pkg::cnt_t'(1);
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			held_mem[cmd_q.wr_addr[AW-1:0]] <= cmd_q.ch;
		end
		if (rd_en) begin
			rd_data_s1 <= held_mem[idx_q[AW-1:0]];
		end
	end

	assign of_push      = tok_valid_s1;
	assign of_data.ch   = tok_mem_s1 ? rd_data_s1 : tok_byte_s1;
	assign of_data.last = tok_last_s1;

endmodule

`default_nettype wire

>>> src/lfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lfs_checker: port-level checks for the line fold stream
// Watches reset state, result stability and queue flag movement.
// ---------------------------------------------------------------------------
module lfs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       push,
	input wire logic       full,
	input wire logic       pop,
	input wire logic       empty,
	input wire logic [7:0] out_ch,
	input wire logic       last
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("result queue not empty in reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_ch) && $stable(last))
		else $error("waiting result changed");

	a_empty_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result vanished without pop");

	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("input went full without a request");

endmodule

bind line_fold_stream_top lfs_checker u_lfs_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.push  (push),
	.full  (full),
	.pop   (pop),
	.empty (empty),
	.out_ch(out_ch),
	.last  (last)
);

`default_nettype wire

>>> tb/sv/line_fold_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_fold_checker: output predictor and scoreboard for the line folder
// Watches the config, request and result channels. Each accepted request
// byte is run through a local copy of the folding state, and the output
// bytes it must cause are queued and compared in order with the results.
// ---------------------------------------------------------------------------
module line_fold_checker #(
	parameter int MAX_COLUMN = lfs_pkg::MAX_COLUMN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [5:0] cfg_wdata,
	input  wire logic       push,
	input  wire logic [7:0] ch,
	input  wire logic       full,
	input  wire logic       pop,
	input  wire logic [7:0] out_ch,
	input  wire logic       last,
	input  wire logic       empty,
	output int              due_count,
	output int              mismatches
);

	lfs_pkg::res_t  bytes_due[$];
	logic [5:0]     fold_reg;
	int             col;
	lfs_pkg::byte_t held[MAX_COLUMN];
	int             held_n;
	bit             space_held;
	bit             line_open;

	task automatic fold_byte(input lfs_pkg::byte_t c);
		lfs_pkg::res_t produced[$];
		int            f;
		int            after;
		f = fold_reg;
		if (f < 2)
			f = 2;
		if (f > MAX_COLUMN)
			f = MAX_COLUMN;
		if (c == lfs_pkg::CH_NEWLINE) begin
			if (line_open) begin
				for (int i = 0; i < held_n; i++)
					produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: held[i]});
				produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: lfs_pkg::CH_NEWLINE});
			end
			col = 0;
			held_n = 0;
			space_held = 1'b0;
			line_open = 1'b0;
		end else begin
			line_open = 1'b1;
			col++;
			if (c == lfs_pkg::CH_SPACE) begin
				for (int i = 0; i < held_n; i++)
					produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: held[i]});
				held[0] = lfs_pkg::CH_SPACE;
				held_n = 1;
				space_held = 1'b1;
			end else if (space_held) begin
				if (held_n < MAX_COLUMN) begin
					held[held_n] = c;
					held_n++;
				end
			end else if (col < f) begin
				produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: c});
			end
			if (col >= f) begin
				if (space_held) begin
					// break at the held space, which is dropped
					after = held_n - 1;
					produced.push_back(lfs_pkg::res_t'{last: 1'b0,
						ch: lfs_pkg::CH_NEWLINE});
					for (int i = 1; i < held_n; i++)
						produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: held[i]});
					held_n = 0;
					space_held = 1'b0;
					col = after;
				end else begin
					produced.push_back(lfs_pkg::res_t'{last: 1'b0,
						ch: lfs_pkg::CH_HYPHEN});
					produced.push_back(lfs_pkg::res_t'{last: 1'b0,
						ch: lfs_pkg::CH_NEWLINE});
					produced.push_back(lfs_pkg::res_t'{last: 1'b0, ch: c});
					col = 1;
				end
			end
			col = col & 63;
		end
		if (produced.size() != 0)
			produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i])
			bytes_due.push_back(produced[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lfs_pkg::res_t want;
		if (!arst_n) begin
			bytes_due.delete();
			fold_reg = lfs_pkg::FOLD_RESET;
			col = 0;
			held_n = 0;
			space_held = 1'b0;
			line_open = 1'b0;
			mismatches = 0;
			due_count <= 0;
		end else begin
			if (cfg_we)
				fold_reg = cfg_wdata;
			if (push && !full)
				fold_byte(ch);
			if (pop && !empty) begin
				if (bytes_due.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none actual out_ch=%02h last=%0b",
						$time, out_ch, last);
				end else begin
					want = bytes_due.pop_front();
					if (out_ch !== want.ch) begin
						mismatches++;
						$display("%0t: out_ch expected %02h actual %02h",
							$time, want.ch, out_ch);
					end
					if (last !== want.last) begin
						mismatches++;
						$display("%0t: last expected %0b actual %0b",
							$time, want.last, last);
					end
				end
			end
			due_count <= bytes_due.size();
		end
	end

endmodule

>>> tb/sv/tb_line_fold_stream_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_line_fold_stream_top: testbench for the line folder
// Drives directed text covering folds at a space, hyphen breaks, empty
// lines and odd bytes, then random word streams under several fold
// columns and idle patterns, including a long result hold-off.
// ---------------------------------------------------------------------------
module tb_line_fold_stream_top;

	localparam int LIMIT      = 400000;
	localparam int DRAIN_GAP  = 40;
	localparam int HOLD_LEN   = 500;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [5:0] cfg_wdata = '0;
	logic       push      = 1'b0;
	logic [7:0] ch        = '0;
	logic       pop       = 1'b0;
	logic       hold_go   = 1'b0;
	logic       full;
	logic [7:0] out_ch;
	logic       last;
	logic       empty;

	int due_count;
	int mismatches;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int hold_left;
	int cycles = 0;

	line_fold_stream_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.ch        (ch),
		.full      (full),
		.pop       (pop),
		.out_ch    (out_ch),
		.last      (last),
		.empty     (empty)
	);

	line_fold_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.ch         (ch),
		.full       (full),
		.pop        (pop),
		.out_ch     (out_ch),
		.last       (last),
		.empty      (empty),
		.due_count  (due_count),
		.mismatches (mismatches)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("line_fold_stream_top: mismatch");
			$finish;
		end
	end

	// long result hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_LEN;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		pop <= (hold_left == 0) && ($urandom_range(0, 99) >= pop_stall_pct);
	end

	task automatic send_byte(input lfs_pkg::byte_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		ch <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// words of random length with occasional long words and raw noise
	task automatic send_text(input int n);
		int             sent;
		int             len;
		int             k;
		lfs_pkg::byte_t b;
		sent = 0;
		while (sent < n) begin
			k = $urandom_range(0, 99);
			if (k < 8) begin
				len = $urandom_range(1, 6);
				repeat (len)
					send_byte(lfs_pkg::byte_t'($urandom));
				sent += len;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
					: $urandom_range(1, 9);
				for (int i = 0; i < len; i++) begin
					b = 8'd97 + 8'($urandom_range(0, 25));
					if ($urandom_range(0, 19) == 0)
						b = 8'($urandom_range(33, 126));
					send_byte(b);
				end
				sent += len;
				k = $urandom_range(0, 99);
				if (k < 80) begin
					send_byte(lfs_pkg::CH_SPACE);
					sent++;
					if (k >= 70) begin
						send_byte(lfs_pkg::CH_SPACE);
						sent++;
					end
				end else begin
					send_byte(lfs_pkg::CH_NEWLINE);
					sent++;
					if (k >= 92) begin
						send_byte(lfs_pkg::CH_NEWLINE);
						sent++;
					end
				end
			end
		end
	endtask

	task automatic run_phase(input logic [5:0] fold, input int idle_pct,
		input int stall_pct, input int n, input bit squeeze);
		push <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (DRAIN_GAP)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= fold;
		@(negedge clk);
		cfg_we <= 1'b0;
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		if (squeeze) begin
			hold_go <= 1'b1;
			@(negedge clk);
			hold_go <= 1'b0;
		end
		send_text(n);
	endtask

	initial begin
		string          text;
		lfs_pkg::byte_t odd[4];
		text = "\nabc \nab cdefgh";
		odd = '{8'hFF, 8'h00, 8'h09, 8'h0D};
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_phase(6'd4, 0, 0, 0, 1'b0);
		for (int i = 0; i < text.len(); i++)
			send_byte(lfs_pkg::byte_t'(text[i]));
		foreach (odd[i])
			send_byte(odd[i]);
		send_byte(lfs_pkg::CH_NEWLINE);

		run_phase(6'd32, 0, 0, 60, 1'b0);
		run_phase(6'd2, 59, 0, 60, 1'b0);
		run_phase(6'd63, 0, 59, 60, 1'b0);
		run_phase(6'd0, 12, 12, 60, 1'b0);
		run_phase(6'd7, 0, 0, 60, 1'b1);
		run_phase(6'd33, 0, 0, 60, 1'b0);
		run_phase(6'd1, 12, 12, 30, 1'b0);
		run_phase(6'($urandom_range(3, 31)), 59, 59, 30, 1'b0);
		push <= 1'b0;

		while (due_count != 0)
			@(negedge clk);
		repeat (DRAIN_GAP)
			@(negedge clk);
		if (mismatches == 0) begin
			$display("line_fold_stream_top: match");
		end else begin
			$display("line_fold_stream_top: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
src/lfs_pkg.sv
src/lfs_fifo.sv
src/lfs_front.sv
src/lfs_back.sv
src/line_fold_stream_top.sv
src/lfs_checker.sv
tb/sv/line_fold_checker.sv
tb/sv/tb_line_fold_stream_top.sv
